[design/mlp_pkg.sv]
// ============================================================================
// mlp_pkg
// Shared constants, register codes, weight bundle and tanh table builder for
// the 2-4-1 perceptron forward pass.
// ============================================================================
package mlp_pkg;

    localparam int HIDDEN_UNITS_DEF     = 4;
    localparam int FRACTION_BITS_DEF    = 12;
    localparam int TANH_TABLE_DEPTH_DEF = 256;

    localparam int X_W            = 16;
    localparam int W_W            = 16;
    localparam int Y_OUT_W        = 14;
    localparam int LANES_PER_WORD = 4;
    localparam int CFG_DATA_W     = 64;
    localparam int PADDR_W        = 6;
    localparam int REG_SEL_LSB    = 3;
    localparam int REG_SEL_W      = PADDR_W - REG_SEL_LSB;

    // hidden products are 16x16; two of them and the bias are summed
    localparam int PROD_W = X_W + W_W;
    localparam int HACC_W = PROD_W + 2;

    typedef enum logic [REG_SEL_W-1:0] {
        REG_W_X1     = 3'd0,
        REG_W_X2     = 3'd1,
        REG_B_HIDDEN = 3'd2,
        REG_W_OUT    = 3'd3,
        REG_B_OUT    = 3'd4
    } mlp_reg_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] w_x1;
        logic [CFG_DATA_W-1:0] w_x2;
        logic [CFG_DATA_W-1:0] b_hidden;
        logic [CFG_DATA_W-1:0] w_out;
        logic signed [W_W-1:0] b_out;
    } mlp_weights_t;

    // Weight of a unit from a packed word; units past the fourth get zero.
    function automatic logic signed [W_W-1:0] word_lane(input logic [CFG_DATA_W-1:0] word,
                                                         input int unit);
        logic [CFG_DATA_W-1:0] shifted;
        shifted = word >> (W_W * unit);
        if (unit < LANES_PER_WORD)
            return shifted[W_W-1:0];
        return '0;
    endfunction

    // One tanh table entry, evaluated at elaboration. Entry i sits at the
    // midpoint of its bin; exp(-2x) comes from a Q30 series raised to the 16th.
    function automatic longint tanh_entry(input int Index, input int Frac, input int Depth);
        longint      m;
        longint      sum;
        logic [63:0] mag;
        logic [63:0] u;
        logic [63:0] term;
        logic [63:0] v;
        logic [63:0] Kterm;
        logic [63:0] num;
        logic [63:0] Den;
        logic [63:0] TwoDepth;
        logic [63:0] t;
        logic [63:0] one_q30;
        one_q30  = 64'd1 << 30;
        m        = longint'(2 * Index + 1 - Depth);
        mag      = (m < 0) ? 64'(-m) : 64'(m);
        TwoDepth = 64'(2 * Depth);
        u        = (mag << 30) / TwoDepth;
        term     = one_q30;
        sum      = longint'(one_q30);
        for (int k = 1; k <= 12; k++) begin
            Kterm = 64'(k);
            term  = ((term * u) >> 30) / Kterm;
            if ((k % 2) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        v = 64'(sum);
        for (int k = 0; k < 4; k++)
            v = (v * v) >> 30;
        num = (v > one_q30) ? 64'd0 : one_q30 - v;
        Den = one_q30 + v;
        t   = ((num << Frac) + (Den >> 1)) / Den;
        return (m < 0) ? -longint'(t) : longint'(t);
    endfunction

endpackage

[design/mlp_if.sv]
// ============================================================================
// mlp_if
// Valid/ready stream channels for the input vector and the network output.
// ============================================================================
interface mlp_in_if;
    import mlp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic signed [X_W-1:0] x_one;
    logic signed [X_W-1:0] x_two;

    modport source (output valid, output x_one, output x_two, input ready);
    modport sink   (input valid, input x_one, input x_two, output ready);
endinterface

interface mlp_out_if;
    import mlp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [Y_OUT_W-1:0] y_out;

    modport source (output valid, output y_out, input ready);
    modport sink   (input valid, input y_out, output ready);
endinterface

[design/mlp_cfg.sv]
// ============================================================================
// mlp_cfg
// APB register file holding the weight words of both layers.
// ============================================================================
module mlp_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mlp_pkg::PADDR_W-1:0]     paddr,
    input  logic [mlp_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [mlp_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output mlp_pkg::mlp_weights_t           weights
);
    import mlp_pkg::*;

    mlp_weights_t weights_reg;
    mlp_weights_t weights_next;
    mlp_reg_t     sel;
    logic         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel    = mlp_reg_t'(paddr[PADDR_W-1:REG_SEL_LSB]);

    always_comb
    begin
        weights_next = weights_reg;
        if (wr_en)
        begin
            unique case (sel)
                REG_W_X1:     weights_next.w_x1     = pwdata;
                REG_W_X2:     weights_next.w_x2     = pwdata;
                REG_B_HIDDEN: weights_next.b_hidden = pwdata;
                REG_W_OUT:    weights_next.w_out    = pwdata;
                REG_B_OUT:    weights_next.b_out    = pwdata[W_W-1:0];
                default:      weights_next          = weights_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_W_X1:     prdata = weights_reg.w_x1;
            REG_W_X2:     prdata = weights_reg.w_x2;
            REG_B_HIDDEN: prdata = weights_reg.b_hidden;
            REG_W_OUT:    prdata = weights_reg.w_out;
            REG_B_OUT:    prdata = CFG_DATA_W'(unsigned'(weights_reg.b_out));
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            weights_reg <= '0;
        else
            weights_reg <= weights_next;
    end

    assign weights = weights_reg;

endmodule

[design/mlp_hidden.sv]
// ============================================================================
// mlp_hidden
// Input register, per-unit products and bias sum of the hidden layer.
// ============================================================================
module mlp_hidden #(
    parameter int HIDDEN_UNITS  = mlp_pkg::HIDDEN_UNITS_DEF,
    parameter int FRACTION_BITS = mlp_pkg::FRACTION_BITS_DEF
) (
    input  logic                                clk,
    input  logic [2:0]                          en,
    input  mlp_pkg::mlp_weights_t               weights,
    input  logic signed [mlp_pkg::X_W-1:0]      x_one,
    input  logic signed [mlp_pkg::X_W-1:0]      x_two,
    output logic signed [mlp_pkg::HACC_W-1:0]   acc [HIDDEN_UNITS]
);
    import mlp_pkg::*;

    logic signed [X_W-1:0] x1_reg;
    logic signed [X_W-1:0] x2_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x1_reg <= x_one;
            x2_reg <= x_two;
        end
    end

    for (genvar h = 0; h < HIDDEN_UNITS; h++)
    begin : g_unit
        logic signed [W_W-1:0]    w1;
        logic signed [W_W-1:0]    w2;
        logic signed [W_W-1:0]    hb;
        logic signed [PROD_W-1:0] p1_reg;
        logic signed [PROD_W-1:0] p2_reg;
        logic signed [PROD_W-1:0] p1_next;
        logic signed [PROD_W-1:0] p2_next;
        logic signed [HACC_W-1:0] acc_reg;
        logic signed [HACC_W-1:0] acc_next;

        assign w1 = word_lane(weights.w_x1, h);
        assign w2 = word_lane(weights.w_x2, h);
        assign hb = word_lane(weights.b_hidden, h);

        assign p1_next  = x1_reg * w1;
        assign p2_next  = x2_reg * w2;
        assign acc_next = HACC_W'(p1_reg) + HACC_W'(p2_reg)
                        + (HACC_W'(hb) <<< FRACTION_BITS);

        always_ff @(posedge clk)
        begin
            if (en[1])
            begin
                p1_reg <= p1_next;
                p2_reg <= p2_next;
            end
            if (en[2])
                acc_reg <= acc_next;
        end

        assign acc[h] = acc_reg;
    end

endmodule

[design/mlp_tanh.sv]
// ============================================================================
// mlp_tanh
// Two-stage tanh: clamp and scale the sum to a table index, then read the
// constant table.
// ============================================================================
module mlp_tanh #(
    parameter int ACC_W         = mlp_pkg::HACC_W,
    parameter int FRACTION_BITS = mlp_pkg::FRACTION_BITS_DEF,
    parameter int TABLE_DEPTH   = mlp_pkg::TANH_TABLE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic [1:0]                      en,
    input  logic signed [ACC_W-1:0]         acc,
    output logic signed [FRACTION_BITS+1:0] val
);
    import mlp_pkg::*;

    localparam int TW = FRACTION_BITS + 2;
    localparam int OW = 2 * FRACTION_BITS + 3;
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam logic signed [ACC_W-1:0] POS_LIM = ACC_W'(64'sd4 <<< (2 * FRACTION_BITS));
    localparam logic signed [ACC_W-1:0] NEG_LIM = -POS_LIM;
    localparam logic [IW-1:0]           IDX_TOP = IW'(TABLE_DEPTH - 1);

    logic signed [TW-1:0]  rom [TABLE_DEPTH];
    logic signed [ACC_W-1:0] shifted;
    logic [OW-1:0]         offset;
    logic [OW+IW-1:0]      scaled;
    logic [IW-1:0]         idx_reg;
    logic [IW-1:0]         idx_next;
    logic signed [TW-1:0]  val_reg;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_rom
        assign rom[i] = TW'(tanh_entry(i, FRACTION_BITS, TABLE_DEPTH));
    end

    assign shifted = acc + POS_LIM;
    assign offset  = shifted[OW-1:0];
    assign scaled  = (OW+IW)'(offset) * (OW+IW)'(TABLE_DEPTH);

    always_comb
    begin
        if (acc < NEG_LIM)
            idx_next = '0;
        else if (acc >= POS_LIM)
            idx_next = IDX_TOP;
        else
            idx_next = scaled[OW+IW-1:OW];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            idx_reg <= idx_next;
        if (en[1])
            val_reg <= rom[idx_reg];
    end

    assign val = val_reg;

endmodule

[design/mlp_outsum.sv]
// ============================================================================
// mlp_outsum
// Output neuron: hidden activations times output weights, then the sum with
// the output bias.
// ============================================================================
module mlp_outsum #(
    parameter int HIDDEN_UNITS  = mlp_pkg::HIDDEN_UNITS_DEF,
    parameter int FRACTION_BITS = mlp_pkg::FRACTION_BITS_DEF,
    parameter int OACC_W        = FRACTION_BITS + 18 + $clog2(HIDDEN_UNITS + 1)
) (
    input  logic                            clk,
    input  logic [1:0]                      en,
    input  mlp_pkg::mlp_weights_t           weights,
    input  logic signed [FRACTION_BITS+1:0] hv [HIDDEN_UNITS],
    output logic signed [OACC_W-1:0]        sum
);
    import mlp_pkg::*;

    localparam int TW = FRACTION_BITS + 2;
    localparam int PW = TW + W_W;

    logic signed [PW-1:0]     prod_reg [HIDDEN_UNITS];
    logic signed [OACC_W-1:0] sum_reg;
    logic signed [OACC_W-1:0] sum_next;

    for (genvar h = 0; h < HIDDEN_UNITS; h++)
    begin : g_prod
        logic signed [W_W-1:0] wo;
        logic signed [PW-1:0]  prod_next;

        assign wo        = word_lane(weights.w_out, h);
        assign prod_next = hv[h] * wo;

        always_ff @(posedge clk)
        begin
            if (en[0])
                prod_reg[h] <= prod_next;
        end
    end

    always_comb
    begin
        sum_next = OACC_W'(weights.b_out) <<< FRACTION_BITS;
        for (int h = 0; h < HIDDEN_UNITS; h++)
            sum_next = sum_next + OACC_W'(prod_reg[h]);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
            sum_reg <= sum_next;
    end

    assign sum = sum_reg;

endmodule

[design/mlp_2_4_1_tanh_forward.sv]
// ============================================================================
// mlp_2_4_1_tanh_forward
// Pipelined forward pass of a 2-input, 4-hidden, 1-output tanh perceptron.
//
//   Channel   Role      Payload                     Handshake
//   in_item   sink      x_one, x_two (Q3.12)        valid/ready
//   out_item  source    y_out (Q1.12, 14 bits)      valid/ready
//   APB       slave     five weight registers       psel/penable, pready=1
//
// One vector per cycle while the output is not stalled; nine register
// stages from acceptance to y_out valid: input, hidden products, hidden
// sum, index, table, output products, output sum, index, table. A stage
// moves if empty or if the next moves; bubbles close up behind a stall.
// Reset clears the stage valid bits and the weights; no clearing pass.
// ============================================================================
module mlp_2_4_1_tanh_forward #(
    parameter int HIDDEN_UNITS     = mlp_pkg::HIDDEN_UNITS_DEF,
    parameter int FRACTION_BITS    = mlp_pkg::FRACTION_BITS_DEF,
    parameter int TANH_TABLE_DEPTH = mlp_pkg::TANH_TABLE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mlp_pkg::PADDR_W-1:0]     paddr,
    input  logic [mlp_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [mlp_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    mlp_in_if.sink                          in_item,
    mlp_out_if.source                       out_item
);
    import mlp_pkg::*;

    localparam int NST    = 9;
    localparam int TW     = FRACTION_BITS + 2;
    localparam int OACC_W = FRACTION_BITS + 18 + $clog2(HIDDEN_UNITS + 1);

    mlp_weights_t          weights;
    logic [NST-1:0]        valid_reg;
    logic [NST-1:0]        valid_next;
    logic [NST-1:0]        adv;
    logic signed [HACC_W-1:0] hacc [HIDDEN_UNITS];
    logic signed [TW-1:0]  hv [HIDDEN_UNITS];
    logic signed [OACC_W-1:0] oacc;
    logic signed [TW-1:0]  y_val;

    mlp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .weights (weights)
    );

    // advance chain: last stage moves on ready, earlier ones fill bubbles
    always_comb
    begin
        adv[NST-1] = out_item.ready || !valid_reg[NST-1];
        for (int i = NST - 2; i >= 0; i--)
            adv[i] = adv[i+1] || !valid_reg[i];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (adv[0])
            valid_next[0] = in_item.valid;
        for (int i = 1; i < NST; i++)
        begin
            if (adv[i])
                valid_next[i] = valid_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_item.ready  = adv[0];
    assign out_item.valid = valid_reg[NST-1];

    mlp_hidden #(
        .HIDDEN_UNITS  (HIDDEN_UNITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_hidden (
        .clk     (clk),
        .en      (adv[2:0]),
        .weights (weights),
        .x_one   (in_item.x_one),
        .x_two   (in_item.x_two),
        .acc     (hacc)
    );

    for (genvar h = 0; h < HIDDEN_UNITS; h++)
    begin : g_htanh
        mlp_tanh #(
            .ACC_W         (HACC_W),
            .FRACTION_BITS (FRACTION_BITS),
            .TABLE_DEPTH   (TANH_TABLE_DEPTH)
        ) u_tanh (
            .clk (clk),
            .en  (adv[4:3]),
            .acc (hacc[h]),
            .val (hv[h])
        );
    end

    mlp_outsum #(
        .HIDDEN_UNITS  (HIDDEN_UNITS),
        .FRACTION_BITS (FRACTION_BITS),
        .OACC_W        (OACC_W)
    ) u_outsum (
        .clk     (clk),
        .en      (adv[6:5]),
        .weights (weights),
        .hv      (hv),
        .sum     (oacc)
    );

    mlp_tanh #(
        .ACC_W         (OACC_W),
        .FRACTION_BITS (FRACTION_BITS),
        .TABLE_DEPTH   (TANH_TABLE_DEPTH)
    ) u_otanh (
        .clk (clk),
        .en  (adv[8:7]),
        .acc (oacc),
        .val (y_val)
    );

    assign out_item.y_out = Y_OUT_W'(y_val);

endmodule

[design/mlp_checker.sv]
// ============================================================================
// mlp_checker
// Port-level checks on the stream channels of the perceptron pipeline.
// ============================================================================
module mlp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [mlp_pkg::Y_OUT_W-1:0] y_out
);
    import mlp_pkg::*;

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // with the last stage free, every stage can take a transaction
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output transaction dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(y_out))
        else $error("output payload changed while stalled");

endmodule

bind mlp_2_4_1_tanh_forward mlp_checker u_mlp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_item.ready),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .y_out     (out_item.y_out)
);
